>>> hw/rtl/wrs_pkg.sv
// Shared types and constants for the water ripple stencil step.
// Holds the coefficients, register codes, controller states and command structs.
// Used by the controller, datapath and top of the block; depends on nothing.
package wrs_pkg;

  localparam int MAX_COLS_DEF    = 256;
  localparam int VALUE_WIDTH_DEF = 24;

  localparam int DAMP_W    = 16;
  localparam int LEN_W     = 9;
  localparam int ROW_W     = 9;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int COEF_W    = 24;

  localparam logic signed [COEF_W-1:0] THIRD_Q24  = 24'sd5592405;
  localparam logic signed [COEF_W-1:0] CORNER_Q24 = 24'sd1977214;

  localparam logic [DAMP_W-1:0] DAMPING_RESET     = 16'd62259;
  localparam logic [LEN_W-1:0]  LINE_LENGTH_RESET = 9'd102;
  localparam logic [LEN_W-1:0]  LEN_MIN           = 9'd3;
  localparam logic [ROW_W-1:0]  ROW_MAX           = 9'd511;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DAMPING     = 1'b0,
    REG_LINE_LENGTH = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic clear_done;
  } dp_status_t;

endpackage

>>> hw/rtl/wrs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read data returns the old contents on a same-address write; no dependencies.
module wrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 258
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/wrs_ctrl.sv
// Controller of the ripple stencil: runs the clearing pass after reset, then
// gates the input handshake and the pipeline advance. Depends on wrs_pkg.
module wrs_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  wrs_pkg::dp_status_t status_i,
  output logic                in_ready_o,
  output wrs_pkg::dp_cmd_t    cmd_o
);
  import wrs_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    advance       = !status_i.out_valid || out_ready_i;
    in_ready_o    = (state_q == ST_RUN) && advance;
    cmd_o.clear   = (state_q == ST_CLEAR);
    cmd_o.advance = advance;
    cmd_o.accept  = in_ready_o && in_valid_i;
  end

`ifndef SYNTHESIS
  a_accept_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |-> (state_q == ST_RUN))
    else $error("Input word accepted during the clearing pass.");

  a_run_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (state_q == ST_RUN))
    else $error("Controller left the run state.");

  a_clear_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && !status_i.clear_done) |=> (state_q == ST_CLEAR))
    else $error("Clearing pass ended early.");
`endif

endmodule

>>> hw/rtl/wrs_datapath.sv
// Datapath of the ripple stencil: position counters, line stores, older-height
// delay line, 3x3 window and the arithmetic pipeline. Depends on wrs_pkg, wrs_ram.
module wrs_datapath #(
  parameter int MAX_COLS    = wrs_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = wrs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wrs_pkg::dp_cmd_t              cmd_i,
  output wrs_pkg::dp_status_t           status_o,
  input  logic                          cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wrs_pkg::DAMP_W-1:0]    cfg_wdata_i,
  input  logic [VALUE_WIDTH-1:0]        cur_height_i,
  input  logic [VALUE_WIDTH-1:0]        old_height_i,
  input  logic                          frame_start_i,
  output logic [VALUE_WIDTH-1:0]        new_height_o,
  output logic [wrs_pkg::IDX_W-1:0]     out_row_o,
  output logic [wrs_pkg::IDX_W-1:0]     out_col_o
);
  import wrs_pkg::*;

  localparam int VW          = VALUE_WIDTH;
  localparam int LINE_DEPTH  = MAX_COLS + 2;
  localparam int DELAY_DEPTH = MAX_COLS + 3;
  localparam int CW          = $clog2(LINE_DEPTH);
  localparam int DW          = $clog2(DELAY_DEPTH);
  localparam int CMPW        = (CW + 1 > LEN_W) ? CW + 1 : LEN_W;
  localparam int XW          = CMPW + 1;
  localparam int EW          = VW + 2;
  localparam int PW          = EW + COEF_W;
  localparam int AW          = VW + 27;
  localparam int PREW        = AW - 24;
  localparam int PRW         = PREW + DAMP_W + 1;
  localparam int RW          = PRW - 16;

  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (VW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (VW - 1)));

  // Configuration registers.
  logic [DAMP_W-1:0] damping_q;
  logic [LEN_W-1:0]  line_length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damping_q     <= DAMPING_RESET;
      line_length_q <= LINE_LENGTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_DAMPING:     damping_q     <= cfg_wdata_i;
        REG_LINE_LENGTH: line_length_q <= cfg_wdata_i[LEN_W-1:0];
      endcase
    end
  end

  // Position tracking at the input.
  logic [CW-1:0]    col_q, col_now;
  logic [ROW_W-1:0] row_q, row_now;
  logic [DW-1:0]    wp_q, wp_next, rd_addr;
  logic [DW-1:0]    clr_q;
  logic [CMPW-1:0]  len_ext, len_eff, col_m2;
  logic [XW-1:0]    lp1, wp_x, rd_x;
  logic [ROW_W-1:0] row_m2;
  logic             col_wrap, produce_now, fwd_now, clr_in_line, clear_done;

  always_comb begin
    col_now  = frame_start_i ? '0 : col_q;
    row_now  = frame_start_i ? '0 : row_q;
    len_ext  = CMPW'(line_length_q);
    if (len_ext < CMPW'(LEN_MIN)) begin
      len_eff = CMPW'(LEN_MIN);
    end else if (len_ext > CMPW'(LINE_DEPTH)) begin
      len_eff = CMPW'(LINE_DEPTH);
    end else begin
      len_eff = len_ext;
    end
    col_wrap    = (CMPW'(col_now) + CMPW'(1)) >= len_eff;
    produce_now = (row_now >= ROW_W'(2)) && (col_now >= CW'(2));
    row_m2      = row_now - ROW_W'(2);
    col_m2      = CMPW'(col_now) - CMPW'(2);
    lp1         = XW'(len_eff) + XW'(1);
    wp_x        = XW'(wp_q);
    if (wp_x >= lp1) begin
      rd_x = wp_x - lp1;
    end else begin
      rd_x = wp_x + XW'(DELAY_DEPTH) - lp1;
    end
    rd_addr     = rd_x[DW-1:0];
    wp_next     = (wp_q == DW'(DELAY_DEPTH - 1)) ? '0 : wp_q + DW'(1);
    clr_in_line = XW'(clr_q) < XW'(LINE_DEPTH);
    clear_done  = (clr_q == DW'(DELAY_DEPTH - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      wp_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clear && !clear_done) begin
        clr_q <= clr_q + DW'(1);
      end
      if (cmd_i.accept) begin
        wp_q <= wp_next;
        if (col_wrap) begin
          col_q <= '0;
          row_q <= (row_now != ROW_MAX) ? row_now + ROW_W'(1) : row_now;
        end else begin
          col_q <= col_now + CW'(1);
          row_q <= row_now;
        end
      end
    end
  end

  // Stage 1: line store and delay line read data arrive.
  logic                 s1_vld_q, s1_prod_q, s1_fwd_q;
  logic [CW-1:0]        s1_col_q;
  logic signed [VW-1:0] s1_cur_q;
  logic [IDX_W-1:0]     s1_row8_q, s1_col8_q;
  logic signed [VW-1:0] fwd_top_q, fwd_mid_q;
  logic [VW-1:0]        upper_rd, middle_rd, older_rd;
  logic signed [VW-1:0] top1, mid1;
  logic signed [VW-1:0] win_q [6];
  logic signed [EW-1:0] edge_d, corner_d;
  logic                 s1_wr;

  assign fwd_now = s1_vld_q && (s1_col_q == col_now);
  assign s1_wr   = s1_vld_q && cmd_i.advance;

  wrs_ram #(.WIDTH(VW), .DEPTH(LINE_DEPTH)) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear ? clr_in_line : s1_wr),
    .waddr_i (cmd_i.clear ? clr_q[CW-1:0] : s1_col_q),
    .wdata_i (cmd_i.clear ? '0 : mid1),
    .re_i    (cmd_i.accept),
    .raddr_i (col_now),
    .rdata_o (upper_rd)
  );

  wrs_ram #(.WIDTH(VW), .DEPTH(LINE_DEPTH)) u_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear ? clr_in_line : s1_wr),
    .waddr_i (cmd_i.clear ? clr_q[CW-1:0] : s1_col_q),
    .wdata_i (cmd_i.clear ? '0 : s1_cur_q),
    .re_i    (cmd_i.accept),
    .raddr_i (col_now),
    .rdata_o (middle_rd)
  );

  wrs_ram #(.WIDTH(VW), .DEPTH(DELAY_DEPTH)) u_older (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clear || cmd_i.accept),
    .waddr_i (cmd_i.clear ? clr_q : wp_q),
    .wdata_i (cmd_i.clear ? '0 : old_height_i),
    .re_i    (cmd_i.accept),
    .raddr_i (rd_addr),
    .rdata_o (older_rd)
  );

  // A frame start can revisit the column just written, so that write is forwarded.
  always_comb begin
    top1     = s1_fwd_q ? fwd_top_q : $signed(upper_rd);
    mid1     = s1_fwd_q ? fwd_mid_q : $signed(middle_rd);
    edge_d   = EW'(win_q[3]) + EW'(win_q[5]) + EW'(win_q[1]) + EW'(mid1);
    corner_d = EW'(win_q[0]) + EW'(win_q[2]) + EW'(top1) + EW'(s1_cur_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      s1_col_q  <= col_now;
      s1_cur_q  <= $signed(cur_height_i);
      s1_prod_q <= produce_now;
      s1_fwd_q  <= fwd_now;
      s1_row8_q <= row_m2[IDX_W-1:0];
      s1_col8_q <= col_m2[IDX_W-1:0];
    end
    if (s1_wr) begin
      fwd_top_q <= mid1;
      fwd_mid_q <= s1_cur_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.advance) begin
      s1_vld_q <= cmd_i.accept;
      if (s1_vld_q) begin
        win_q[0] <= win_q[3];
        win_q[1] <= win_q[4];
        win_q[2] <= win_q[5];
        win_q[3] <= top1;
        win_q[4] <= mid1;
        win_q[5] <= s1_cur_q;
      end
    end
  end

  // Stages 2 to 5 and the output register.
  logic                   s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q;
  logic signed [EW-1:0]   s2_edge_q, s2_corner_q;
  logic signed [VW-1:0]   s2_older_q, s3_older_q;
  logic signed [PW-1:0]   s3_pe_q, s3_pc_q;
  logic signed [PREW-1:0] s4_pre_q;
  logic signed [PRW-1:0]  s5_prod_q;
  logic [IDX_W-1:0]       s2_row_q, s3_row_q, s4_row_q, s5_row_q, out_row_q;
  logic [IDX_W-1:0]       s2_col_q, s3_col_q, s4_col_q, s5_col_q, out_col_q;
  logic [VW-1:0]          out_new_q;
  logic signed [AW-1:0]   acc;
  logic signed [PRW-1:0]  rnd;
  logic signed [RW-1:0]   res;
  logic [VW-1:0]          sat;

  always_comb begin
    acc = AW'(s3_pe_q) + AW'(s3_pc_q) - (AW'(s3_older_q) <<< 24) + AW'(32'sd8388608);
    rnd = s5_prod_q + PRW'(32'sd32768);
    res = rnd[PRW-1:16];
    if (res > SAT_HI) begin
      sat = SAT_HI[VW-1:0];
    end else if (res < SAT_LO) begin
      sat = SAT_LO[VW-1:0];
    end else begin
      sat = res[VW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.advance) begin
      s2_edge_q   <= edge_d;
      s2_corner_q <= corner_d;
      s2_older_q  <= $signed(older_rd);
      s2_row_q    <= s1_row8_q;
      s2_col_q    <= s1_col8_q;
      s3_pe_q     <= PW'(s2_edge_q) * PW'(THIRD_Q24);
      s3_pc_q     <= PW'(s2_corner_q) * PW'(CORNER_Q24);
      s3_older_q  <= s2_older_q;
      s3_row_q    <= s2_row_q;
      s3_col_q    <= s2_col_q;
      s4_pre_q    <= acc[AW-1:24];
      s4_row_q    <= s3_row_q;
      s4_col_q    <= s3_col_q;
      s5_prod_q   <= PRW'(s4_pre_q) * PRW'($signed({1'b0, damping_q}));
      s5_row_q    <= s4_row_q;
      s5_col_q    <= s4_col_q;
      out_new_q   <= sat;
      out_row_q   <= s5_row_q;
      out_col_q   <= s5_col_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (cmd_i.advance) begin
      s2_vld_q  <= s1_vld_q && s1_prod_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  assign new_height_o        = out_new_q;
  assign out_row_o           = out_row_q;
  assign out_col_o           = out_col_q;
  assign status_o.out_valid  = out_vld_q;
  assign status_o.clear_done = clear_done;

`ifndef SYNTHESIS
  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(col_q) < CMPW'(LINE_DEPTH))
    else $error("Column counter beyond the line store depth.");

  a_wp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(wp_q) < XW'(DELAY_DEPTH))
    else $error("Delay line pointer beyond its depth.");

  a_quiet_during_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |-> (!s1_vld_q && !s2_vld_q && !out_vld_q))
    else $error("Pipeline holds a word during the clearing pass.");
`endif

endmodule

>>> hw/rtl/water_ripple_stencil_step.sv
// A result word leaves the registered pipeline on the master side after the input
// word that completes its 3x3 window is accepted. Throughput is one word per cycle,
// set by the line stores and delay line, each read once and written once per word.
// A stalled master side holds the whole pipeline and drops s_axis_tready.
// After reset the line stores and the delay line are cleared, one entry a cycle,
// for MAX_COLS+3 entries (259 by default); s_axis_tready stays low during that pass.
module water_ripple_stencil_step #(
  parameter int MAX_COLS    = wrs_pkg::MAX_COLS_DEF,
  parameter int VALUE_WIDTH = wrs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [wrs_pkg::DAMP_W-1:0]            cfg_wdata_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // cur_height, old_height, zero fill
  input  logic [((2*VALUE_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
  // frame_start
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // new_height, out_row, out_col, zero fill
  output logic [((VALUE_WIDTH+16+7)/8)*8-1:0]   m_axis_tdata
);
  import wrs_pkg::*;

  localparam int OUT_W = ((VALUE_WIDTH + 2 * IDX_W + 7) / 8) * 8;

  dp_cmd_t                cmd;
  dp_status_t             status;
  logic [VALUE_WIDTH-1:0] new_height;
  logic [IDX_W-1:0]       out_row, out_col;

  wrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .in_ready_o  (s_axis_tready),
    .cmd_o       (cmd)
  );

  wrs_datapath #(
    .MAX_COLS    (MAX_COLS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cur_height_i  (s_axis_tdata[VALUE_WIDTH-1:0]),
    .old_height_i  (s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
    .frame_start_i (s_axis_tuser),
    .new_height_o  (new_height),
    .out_row_o     (out_row),
    .out_col_o     (out_col)
  );

  assign m_axis_tvalid = status.out_valid;
  assign m_axis_tdata  = OUT_W'({out_col, out_row, new_height});

endmodule

>>> tb/wrs_checker.sv
// Scoreboard for the water ripple stencil step: follows the register port and both streams.
// Predicts each interior cell from a private copy of the line stores and the window.
// Depends on wrs_pkg for widths, coefficients and register codes.
module wrs_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wrs_pkg::DAMP_W-1:0]          cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  // cur_height, old_height
  input  logic [47:0]                         s_axis_tdata,
  // frame_start
  input  logic                                s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // new_height, out_row, out_col
  input  logic [39:0]                         m_axis_tdata,
  output int                                  pending_o,
  output int                                  errors_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wrs_pkg::*;

  localparam int SPAN_MAX  = MAX_COLS_DEF + 2;
  localparam int DELAY_LEN = MAX_COLS_DEF + 3;

  typedef struct packed {
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [23:0] height;
  } ripple_cell_t;

  logic signed [23:0] upper_row [SPAN_MAX];
  logic signed [23:0] middle_row [SPAN_MAX];
  logic signed [23:0] win [6];
  logic signed [23:0] older_line [DELAY_LEN];
  int unsigned        wr_ptr;
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  logic [DAMP_W-1:0]  damp_q;
  logic [LEN_W-1:0]   len_q;
  ripple_cell_t       next_cells [$];

  task automatic step_grid(input logic signed [23:0] cur_h, input logic signed [23:0] old_h,
                           input logic fs);
    int unsigned  span;
    int unsigned  c;
    int unsigned  rd;
    longint       top_h;
    longint       mid_h;
    longint       older_h;
    longint       edges;
    longint       corners;
    longint       acc;
    longint       pre;
    longint       res;
    ripple_cell_t pred;
    span = len_q;
    if (span < LEN_MIN) span = LEN_MIN;
    if (span > SPAN_MAX) span = SPAN_MAX;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt % SPAN_MAX;
    top_h = upper_row[c];
    mid_h = middle_row[c];
    rd = (wr_ptr + DELAY_LEN - (span + 1)) % DELAY_LEN;
    older_h = older_line[rd];
    if (row_cnt >= 2 && c >= 2) begin
      edges = win[3] + win[5] + win[1] + mid_h;
      corners = win[0] + win[2] + top_h + longint'(cur_h);
      acc = edges * longint'(THIRD_Q24) + corners * longint'(CORNER_Q24) - (older_h <<< 24);
      pre = (acc + (64'sd1 <<< 23)) >>> 24;
      res = (pre * longint'({1'b0, damp_q}) + 64'sd32768) >>> 16;
      if (res > 64'sd8388607) res = 64'sd8388607;
      if (res < -64'sd8388608) res = -64'sd8388608;
      pred.height = res[23:0];
      pred.row = 8'(row_cnt - 2);
      pred.col = 8'(c - 2);
      next_cells.push_back(pred);
    end
    older_line[wr_ptr % DELAY_LEN] = old_h;
    wr_ptr = (wr_ptr + 1) % DELAY_LEN;
    upper_row[c] = mid_h[23:0];
    middle_row[c] = cur_h;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top_h[23:0];
    win[4] = mid_h[23:0];
    win[5] = cur_h;
    if (col_cnt + 1 >= span) begin
      col_cnt = 0;
      if (row_cnt < ROW_MAX) row_cnt++;
    end else begin
      col_cnt++;
    end
  endtask

  task automatic check_word(input logic [39:0] word);
    ripple_cell_t got;
    ripple_cell_t want;
    got.height = word[23:0];
    got.row = word[31:24];
    got.col = word[39:32];
    if (next_cells.size() == 0) begin
      errors_o++;
      if (errors_o <= 10) begin
        $display("unexpected result word: height %0d row %0d col %0d",
                 $signed(got.height), got.row, got.col);
      end
    end else begin
      want = next_cells.pop_front();
      if (got.height !== want.height || got.row !== want.row || got.col !== want.col) begin
        errors_o++;
        if (errors_o <= 10) begin
          $display("mismatch: exp height %0d row %0d col %0d, got height %0d row %0d col %0d",
                   $signed(want.height), want.row, want.col,
                   $signed(got.height), got.row, got.col);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SPAN_MAX; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      for (int i = 0; i < DELAY_LEN; i++) older_line[i] = '0;
      for (int i = 0; i < 6; i++) win[i] = '0;
      wr_ptr = 0;
      col_cnt = 0;
      row_cnt = 0;
      damp_q = DAMPING_RESET;
      len_q = LINE_LENGTH_RESET;
      next_cells.delete();
      pending_o = 0;
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_DAMPING: begin
            damp_q = cfg_wdata_i;
          end
          REG_LINE_LENGTH: begin
            len_q = cfg_wdata_i[LEN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        step_grid(s_axis_tdata[23:0], s_axis_tdata[47:24], s_axis_tuser);
      end
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      pending_o = next_cells.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// Top of the water ripple stencil step testbench: clock, reset, register writes and grid streams.
// Frames run in raster order under changing damping and line lengths with random idling.
// Depends on wrs_pkg, the block and wrs_checker, which predicts and compares the results.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wrs_pkg::*;

  localparam int          VW             = VALUE_WIDTH_DEF;
  localparam int          S_W            = ((2 * VW + 7) / 8) * 8;
  localparam int          M_W            = ((VW + 16 + 7) / 8) * 8;
  localparam int          SPAN_MAX       = MAX_COLS_DEF + 2;
  localparam int          ITEM_GOAL      = 1900;
  localparam int          ROW_WRAP_CELLS = 3 * 259;
  localparam int          QUIET_CYCLES   = 12;
  localparam int unsigned CYCLE_LIMIT    = 400000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  cfg_reg_e         cfg_index_i = REG_DAMPING;
  logic [DAMP_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [S_W-1:0]   s_axis_tdata = '0;
  logic             s_axis_tuser = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [M_W-1:0]   m_axis_tdata;
  int               pending;
  int               mismatches;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int unsigned      sent_items = 0;
  int unsigned      cycle_cnt = 0;

  water_ripple_stencil_step dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  wrs_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .errors_o      (mismatches)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [23:0] pick_height();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2, 3, 4: return 24'($urandom_range(131072)) - 24'd65536;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 32;
        recv_idle_pct = 68;
      end
      1: begin
        send_idle_pct = 68;
        recv_idle_pct = 32;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic push_cell(input logic [23:0] cur_h, input logic [23:0] old_h, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {old_h, cur_h};
    s_axis_tuser <= fs;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent_items++;
  endtask

  // Returns on a rising edge once every predicted cell has come out.
  task automatic hold_until_drained(input int extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (extra + 1) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [15:0] damp_word, input logic [15:0] len_word);
    hold_until_drained(QUIET_CYCLES);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_DAMPING;
    cfg_wdata_i <= damp_word;
    @(posedge clk_i);
    cfg_index_i <= REG_LINE_LENGTH;
    cfg_wdata_i <= len_word;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random_phase();
    logic [15:0] damp_val;
    logic [8:0]  len_val;
    int unsigned span;
    int unsigned frames;
    int unsigned cells;
    int unsigned kind;
    int unsigned restart_at;
    logic        fs;
    case ($urandom_range(5))
      0: damp_val = 16'h0000;
      1: damp_val = 16'hFFFF;
      2: damp_val = DAMPING_RESET;
      default: damp_val = 16'($urandom);
    endcase
    case ($urandom_range(9))
      0: len_val = 9'($urandom_range(2));
      1: len_val = LEN_MIN;
      default: len_val = 9'($urandom_range(4, 12));
    endcase
    load_regs(damp_val, {7'($urandom), len_val});
    span = (len_val < LEN_MIN) ? LEN_MIN : len_val;
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++) begin
      kind = $urandom_range(9);
      cells = span * $urandom_range(3, 7);
      if (kind == 0) cells = $urandom_range(1, cells);
      restart_at = (kind == 1) ? $urandom_range(1, cells - 1) : cells;
      if ($urandom_range(7) == 0) hold_until_drained(0);
      for (int i = 0; i < cells; i++) begin
        fs = (i == 0 && !(f == 0 && kind == 2)) || i == restart_at;
        push_cell(pick_height(), pick_height(), fs);
      end
    end
  endtask

  task automatic run_wide_phase(input logic [8:0] len_val, input int unsigned cells);
    load_regs(16'($urandom), {7'($urandom), len_val});
    for (int i = 0; i < cells; i++) push_cell(pick_height(), pick_height(), i == 0);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idle(0);
    load_regs(16'hFFFF, {7'd0, LEN_MIN});
    for (int i = 0; i < 12; i++) push_cell(24'h7FFFFF, 24'h800000, i == 0);
    for (int i = 0; i < 12; i++) push_cell(24'h800000, 24'h7FFFFF, i == 0);
    while (sent_items < ITEM_GOAL / 8) run_random_phase();
    set_idle(1);
    while (sent_items < ITEM_GOAL / 4) run_random_phase();
    run_wide_phase(9'($urandom_range(SPAN_MAX, 511)), 2 * SPAN_MAX + $urandom_range(3, 20));
    set_idle(2);
    do begin
      run_random_phase();
    end while (sent_items < ITEM_GOAL - ROW_WRAP_CELLS);
    // A long run at the shortest line pushes the row counter past 255 so the output row wraps.
    run_wide_phase(LEN_MIN, ROW_WRAP_CELLS);
    hold_until_drained(QUIET_CYCLES);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
